>>> sv/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> sv/saq_pkg.sv
// Package with types and constants of the shortest-arc quaternion block.
package saq_pkg;
	localparam int QUNIT = 30;
	localparam int QOUT = 14;

	typedef enum logic [1:0] {
		PATH_IDENT = 2'd0,
		PATH_SPARE = 2'd1,
		PATH_GEN   = 2'd2,
		PATH_GENERAL = 2'd3
	} path_t;

	typedef logic signed [31:0] comp_t;

	// Side-band fields carried alongside a normalizer.
	typedef struct packed {
		path_t path;
	} tag_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic signed [15:0] w;
		path_t path;
	} quat_t;
endpackage

>>> sv/saq_if.sv
// Valid/ready channel interface with a generic payload.
interface saq_if #(parameter int W = 16) (input logic clk);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/shortest_arc_quaternion_top.sv
// Shortest-arc rotation quaternion top level.
// One vector pair is accepted every clock cycle when the output side takes results;
// each result passes the source and destination normalizers, which run side by side
// (4 scaling and squaring stages, 8 square-root stages, 8 divider stages), then the
// product, dot/cross and path-selection registers, then the output normalizer, built
// of the same kinds of stages. The rate is set by the fully pipelined square-root and divider stages;
// a stall at the output freezes the whole pipe.
module shortest_arc_quaternion_top
	import saq_pkg::*;
#(
	parameter int VECTOR_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	saq_if.sink   in_ch,
	saq_if.source out_ch
);
`include "assert_macros.svh"
	logic en;
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	logic signed [VECTOR_BITS-1:0] a [3], b [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a[i] = in_ch.data[i*VECTOR_BITS +: VECTOR_BITS];
			b[i] = in_ch.data[(3+i)*VECTOR_BITS +: VECTOR_BITS];
		end
	end

	// First pass: normalize source and destination. The source rides along the first
	// normalizer and the fallback axis along the second.
	localparam int TW1 = 3 * VECTOR_BITS;
	logic signed [63:0] ain [4], bin [4];
	logic signed [31:0] u [4], v [4];
	logic [TW1-1:0] tg_u, tg_v;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ain[i] = 64'(a[i]);
			bin[i] = 64'(b[i]);
		end
		ain[3] = '0;
		bin[3] = '0;
	end
	logic signed [32:0] uo [4], vo [4];
	saq_unit #(.IW(64), .FRAC(QUNIT), .QW(32), .TW(TW1)) u_na (
		.clk(clk), .en(en), .in_v(ain), .tag_in(in_ch.data[TW1-1:0]),
		.out_v(uo), .tag_out(tg_u)
	);
	saq_unit #(.IW(64), .FRAC(QUNIT), .QW(32), .TW(TW1)) u_nb (
		.clk(clk), .en(en), .in_v(bin),
		.tag_in(in_ch.data[9*VECTOR_BITS-1:6*VECTOR_BITS]),
		.out_v(vo), .tag_out(tg_v)
	);
	always_comb
		for (int i = 0; i < 4; i++) begin
			u[i] = uo[i][31:0];
			v[i] = vo[i][31:0];
		end

	// Products stage.
	logic signed [61:0] p_s1 [9];
	logic [2*TW1-1:0] tg_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= u[0] * v[0];
			p_s1[1] <= u[1] * v[1];
			p_s1[2] <= u[2] * v[2];
			p_s1[3] <= u[1] * v[2];
			p_s1[4] <= u[2] * v[1];
			p_s1[5] <= u[2] * v[0];
			p_s1[6] <= u[0] * v[2];
			p_s1[7] <= u[0] * v[1];
			p_s1[8] <= u[1] * v[0];
			tg_s1 <= {tg_v, tg_u};
		end
	end

	// Dot, cross and path selection.
	logic signed [63:0] d_s2;
	logic signed [63:0] g_s2 [4];
	logic [2*TW1-1:0] tg_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			d_s2 <= 64'(p_s1[0]) + 64'(p_s1[1]) + 64'(p_s1[2]);
			g_s2[0] <= 64'(p_s1[3]) - 64'(p_s1[4]);
			g_s2[1] <= 64'(p_s1[5]) - 64'(p_s1[6]);
			g_s2[2] <= 64'(p_s1[7]) - 64'(p_s1[8]);
			tg_s2 <= tg_s1;
		end
	end

	localparam logic signed [63:0] ONE60 = 64'sd1 <<< 60;
	localparam logic signed [63:0] IDMIN = ONE60 - (64'sd1 <<< 36);
	localparam logic signed [63:0] ANMAX = (64'sd1 <<< 40) - ONE60;

	path_t path_s3;
	logic signed [63:0] vec_s3 [4];
	always_ff @(posedge clk) begin
		logic signed [VECTOR_BITS-1:0] ra [3], rf [3];
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ra[i] = tg_s2[i*VECTOR_BITS +: VECTOR_BITS];
				rf[i] = tg_s2[(3+i)*VECTOR_BITS +: VECTOR_BITS];
			end
			if (d_s2 >= IDMIN) begin
				path_s3 <= PATH_IDENT;
				vec_s3[0] <= '0; vec_s3[1] <= '0; vec_s3[2] <= '0;
				vec_s3[3] <= 64'sd1;
			end else if (d_s2 < ANMAX) begin
				vec_s3[3] <= '0;
				if (rf[0] != 0 || rf[1] != 0 || rf[2] != 0) begin
					path_s3 <= PATH_SPARE;
					vec_s3[0] <= 64'(rf[0]); vec_s3[1] <= 64'(rf[1]);
					vec_s3[2] <= 64'(rf[2]);
				end else begin
					path_s3 <= PATH_GEN;
					if (ra[2] == 0 && ra[1] == 0) begin
						vec_s3[0] <= 64'(ra[2]); vec_s3[1] <= '0;
						vec_s3[2] <= -64'(ra[0]);
					end else begin
						vec_s3[0] <= '0; vec_s3[1] <= -64'(ra[2]);
						vec_s3[2] <= 64'(ra[1]);
					end
				end
			end else begin
				path_s3 <= PATH_GENERAL;
				vec_s3[0] <= g_s2[0]; vec_s3[1] <= g_s2[1]; vec_s3[2] <= g_s2[2];
				vec_s3[3] <= ONE60 + d_s2;
			end
		end
	end

	// Second pass: normalize the chosen vector to Q1.14.
	logic signed [16:0] qo [4];
	logic [1:0] ptag;
	saq_unit #(.IW(64), .FRAC(QOUT), .QW(16), .TW(2)) u_nq (
		.clk(clk), .en(en), .in_v(vec_s3), .tag_in(path_s3),
		.out_v(qo), .tag_out(ptag)
	);

	// Valid bits travel in a shift line as deep as the datapath.
	localparam int UL1 = 4 + 8 + 8;
	localparam int UL2 = 4 + 8 + 4;
	localparam int DEPTH = UL1 + 3 + UL2;
	logic [DEPTH-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[DEPTH-2:0], in_ch.valid};
	end
	assign out_ch.valid = vld_q[DEPTH-1];
	assign out_ch.data = {qo[0][15:0], qo[1][15:0], qo[2][15:0], qo[3][15:0], ptag};

	`ASSERT_NEXT(a_stall_holds, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
	`ASSERT_ALWAYS(a_ready_when_empty, clk, arst_n, out_ch.valid || in_ch.ready)
	`ASSERT_NEXT(a_valid_travels, clk, arst_n, en && vld_q[DEPTH-2], out_ch.valid)
endmodule

>>> sv/saq_isqrt.sv
// Pipelined integer square root, four result bits per stage.
module saq_isqrt
	import saq_pkg::*;
#(
	parameter int NW = 64,
	parameter int TW = 8
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] n,
	input  logic [TW-1:0] tag_in,
	output logic [NW/2-1:0] root,
	output logic [TW-1:0] tag_out
);
	localparam int ST = NW / 8;
	logic [NW-1:0] rem_s [0:ST];
	logic [NW-1:0] res_s [0:ST];
	logic [TW-1:0] tag_s [0:ST];

	assign rem_s[0] = n;
	assign res_s[0] = '0;
	assign tag_s[0] = tag_in;

	for (genvar s = 0; s < ST; s++) begin : g_st
		logic [NW-1:0] rem_c, res_c;
		always_comb begin
			logic [NW-1:0] bitv;
			rem_c = rem_s[s];
			res_c = res_s[s];
			for (int k = 0; k < 4; k++) begin
				bitv = {{(NW-1){1'b0}}, 1'b1} << (NW - 2 - 2 * (4 * s + k));
				if (rem_c >= res_c + bitv) begin
					rem_c = rem_c - (res_c + bitv);
					res_c = (res_c >> 1) + bitv;
				end else begin
					res_c = res_c >> 1;
				end
			end
		end
		logic [NW-1:0] rem_r, res_r;
		logic [TW-1:0] tag_r;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_r <= rem_c;
				res_r <= res_c;
				tag_r <= tag_s[s];
			end
		end
		assign rem_s[s+1] = rem_r;
		assign res_s[s+1] = res_r;
		assign tag_s[s+1] = tag_r;
	end

	assign root = res_s[ST][NW/2-1:0];
	assign tag_out = tag_s[ST];
endmodule

>>> sv/saq_div.sv
// Pipelined restoring divider with rounding to nearest, ties away from zero.
module saq_div
	import saq_pkg::*;
#(
	parameter int NW = 64,
	parameter int DW = 32,
	parameter int QW = 32,
	parameter int TW = 8
) (
	input  logic            clk,
	input  logic            en,
	input  logic [NW-1:0]   num_mag,
	input  logic            neg,
	input  logic [DW-1:0]   den,
	input  logic [TW-1:0]   tag_in,
	output logic signed [QW:0] quo,
	output logic [TW-1:0]   tag_out
);
	// Magnitude plus half the divisor, then long division, four bits per stage.
	localparam int AW = NW + 1;
	localparam int ST = (QW + 3) / 4;
	logic [AW-1:0] rem_s [0:ST];
	logic [QW-1:0] q_s [0:ST];
	logic [DW-1:0] d_s [0:ST];
	logic neg_s [0:ST];
	logic [TW-1:0] tag_s [0:ST];

	assign rem_s[0] = {1'b0, num_mag} + {{(AW-DW+1){1'b0}}, den[DW-1:1]};
	assign q_s[0] = '0;
	assign d_s[0] = den;
	assign neg_s[0] = neg;
	assign tag_s[0] = tag_in;

	for (genvar s = 0; s < ST; s++) begin : g_st
		logic [AW-1:0] rem_c;
		logic [QW-1:0] q_c;
		always_comb begin
			logic [AW+QW-1:0] dsh;
			rem_c = rem_s[s];
			q_c = q_s[s];
			for (int k = 0; k < 4; k++) begin
				if (4 * s + k < QW) begin
					dsh = {{(AW+QW-DW){1'b0}}, d_s[s]} << (QW - 1 - (4 * s + k));
					q_c = q_c << 1;
					if ({{QW{1'b0}}, rem_c} >= dsh) begin
						rem_c = rem_c - dsh[AW-1:0];
						q_c[0] = 1'b1;
					end
				end
			end
		end
		logic [AW-1:0] rem_r;
		logic [QW-1:0] q_r;
		logic [DW-1:0] d_r;
		logic neg_r;
		logic [TW-1:0] tag_r;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_r <= rem_c;
				q_r <= q_c;
				d_r <= d_s[s];
				neg_r <= neg_s[s];
				tag_r <= tag_s[s];
			end
		end
		assign rem_s[s+1] = rem_r;
		assign q_s[s+1] = q_r;
		assign d_s[s+1] = d_r;
		assign neg_s[s+1] = neg_r;
		assign tag_s[s+1] = tag_r;
	end

	assign quo = neg_s[ST] ? -$signed({1'b0, q_s[ST]}) : $signed({1'b0, q_s[ST]});
	assign tag_out = tag_s[ST];
endmodule

>>> sv/saq_unit.sv
// Vector normalizer: range scaling, sum of squares, square root, per-component rounded divide.
module saq_unit
	import saq_pkg::*;
#(
	parameter int IW = 64,
	parameter int FRAC = 30,
	parameter int QW = 32,
	parameter int TW = 8
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [IW-1:0]   in_v [4],
	input  logic [TW-1:0]          tag_in,
	output logic signed [QW:0]     out_v [4],
	output logic [TW-1:0]          tag_out
);
	localparam int LW = $clog2(IW + 1);

	// Stage 1: leading-one position of the largest magnitude, taken from the OR of all magnitudes.
	logic signed [IW-1:0] v_s1 [4];
	logic [LW-1:0] msb_s1;
	logic zero_s1;
	logic [TW-1:0] tag_s1;
	always_ff @(posedge clk) begin
		logic [IW-1:0] orv;
		logic [LW-1:0] p;
		if (en) begin
			orv = '0;
			for (int i = 0; i < 4; i++)
				orv = orv | (in_v[i][IW-1] ? IW'(-in_v[i]) : IW'(in_v[i]));
			p = '0;
			for (int b = 0; b < IW; b++)
				if (orv[b]) p = LW'(b);
			v_s1 <= in_v;
			msb_s1 <= p;
			zero_s1 <= (orv == '0);
			tag_s1 <= tag_in;
		end
	end

	// Stage 2: shift so the largest magnitude lies in [2^29, 2^30); halving truncates.
	logic signed [31:0] t_s2 [4];
	logic zero_s2;
	logic [TW-1:0] tag_s2;
	always_ff @(posedge clk) begin
		logic [IW-1:0] m;
		logic [IW-1:0] r;
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				m = v_s1[i][IW-1] ? IW'(-v_s1[i]) : IW'(v_s1[i]);
				if (msb_s1 >= LW'(29)) r = m >> (msb_s1 - LW'(29));
				else r = m << (LW'(29) - msb_s1);
				t_s2[i] <= v_s1[i][IW-1] ? -$signed(r[31:0]) : $signed(r[31:0]);
			end
			zero_s2 <= zero_s1;
			tag_s2 <= tag_s1;
		end
	end

	// Stage 3: squares.
	logic [59:0] sq_s3 [4];
	logic signed [31:0] t_s3 [4];
	logic zero_s3;
	logic [TW-1:0] tag_s3;
	always_ff @(posedge clk) begin
		logic [29:0] a;
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				a = t_s2[i][31] ? 30'(-t_s2[i]) : t_s2[i][29:0];
				sq_s3[i] <= a * a;
			end
			t_s3 <= t_s2;
			zero_s3 <= zero_s2;
			tag_s3 <= tag_s2;
		end
	end

	// Stage 4: sum.
	logic [63:0] sum_s4;
	logic signed [31:0] t_s4 [4];
	logic zero_s4;
	logic [TW-1:0] tag_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4 <= 64'(sq_s3[0]) + 64'(sq_s3[1]) + 64'(sq_s3[2]) + 64'(sq_s3[3]);
			t_s4 <= t_s3;
			zero_s4 <= zero_s3;
			tag_s4 <= tag_s3;
		end
	end

	localparam int XW = 4 * 32 + 1 + TW;
	logic [XW-1:0] xin, xout;
	logic [31:0] root;
	assign xin = {t_s4[0], t_s4[1], t_s4[2], t_s4[3], zero_s4, tag_s4};
	saq_isqrt #(.NW(64), .TW(XW)) u_sqrt (
		.clk(clk), .en(en), .n(sum_s4), .tag_in(xin),
		.root(root), .tag_out(xout)
	);

	logic signed [31:0] t_q [4];
	logic zero_q;
	logic [TW-1:0] tagq;
	assign {t_q[0], t_q[1], t_q[2], t_q[3], zero_q, tagq} = xout;

	for (genvar i = 0; i < 4; i++) begin : g_div
		logic [29:0] am;
		logic [TW:0] tdo;
		logic signed [QW:0] qo;
		assign am = t_q[i][31] ? 30'(-t_q[i]) : t_q[i][29:0];
		saq_div #(.NW(30 + FRAC), .DW(32), .QW(QW), .TW(TW + 1)) u_div (
			.clk(clk), .en(en),
			.num_mag({am, {FRAC{1'b0}}}), .neg(t_q[i][31]),
			.den(zero_q ? 32'd1 : root), .tag_in({zero_q, tagq}),
			.quo(qo), .tag_out(tdo)
		);
		assign out_v[i] = tdo[TW] ? '0 : qo;
		if (i == 0) begin : g_tag
			assign tag_out = tdo[TW-1:0];
		end
	end
endmodule
